### hdl/spbs_pkg.sv
// types, constants and register reset values shared by the button press sequencer
// no dependencies
package spbs_pkg;

  localparam int unsigned SpeedW = 8;
  localparam int unsigned GapW   = 3;
  localparam int unsigned TickW  = 8;

  localparam logic [TickW-1:0] ShortPressRst = 8'd5;
  localparam logic [TickW-1:0] HoldCheckRst  = 8'd2;
  localparam logic [TickW-1:0] ReleaseRst    = 8'd5;
  localparam logic [TickW-1:0] LongThreshRst = 8'd3;

  typedef enum logic [2:0] {
    MODE_OFF     = 3'd0,
    MODE_IDLE    = 3'd1,
    MODE_SHORT   = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_LONG    = 3'd4,
    MODE_CHECK   = 3'd5
  } mode_e;

  typedef enum logic [1:0] {
    BTN_RELEASE  = 2'd0,
    BTN_UP       = 2'd1,
    BTN_DOWN     = 2'd2,
    BTN_DISTANCE = 2'd3
  } btn_e;

  typedef enum logic [1:0] {
    CFG_SHORT_PRESS = 2'd0,
    CFG_HOLD_CHECK  = 2'd1,
    CFG_RELEASE     = 2'd2,
    CFG_LONG_THRESH = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [SpeedW-1:0] desired_speed;
    logic [GapW-1:0]   target_gap;
    logic [SpeedW-1:0] current_set_speed;
    logic [GapW-1:0]   current_set_gap;
    logic              control_permitted;
  } tick_t;

  typedef struct packed {
    logic [TickW-1:0] short_press_ticks;
    logic [TickW-1:0] hold_check_ticks;
    logic [TickW-1:0] release_ticks;
    logic [TickW-1:0] long_press_threshold;
  } cfg_t;

  typedef struct packed {
    logic  valid;
    btn_e  code;
    mode_e mode;
  } res_t;

endpackage

### hdl/spbs_fsm.sv
// mode state machine and tick counters of the button press sequencer
// depends on spbs_pkg
module spbs_fsm (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           advance_i,
  input  spbs_pkg::tick_t tick_i,
  input  spbs_pkg::cfg_t  cfg_i,
  output spbs_pkg::res_t  res_o
);
  import spbs_pkg::*;

  mode_e            mode_q, mode_d;
  logic [TickW-1:0] press_q, press_d;
  logic [TickW-1:0] hold_q, hold_d;
  logic [TickW-1:0] rel_q, rel_d;

  logic [SpeedW-1:0] err;
  logic              gap_bad;
  logic              err_small;
  logic              err_big;
  logic              legal;
  btn_e              spd_btn;
  logic              valid;
  btn_e              code;

  always_comb begin
    err       = (tick_i.desired_speed > tick_i.current_set_speed) ?
                (tick_i.desired_speed - tick_i.current_set_speed) :
                (tick_i.current_set_speed - tick_i.desired_speed);
    gap_bad   = tick_i.target_gap != tick_i.current_set_gap;
    err_small = (err < cfg_i.long_press_threshold) && (err != '0);
    err_big   = err >= cfg_i.long_press_threshold;
    spd_btn   = (tick_i.current_set_speed > tick_i.desired_speed) ? BTN_DOWN : BTN_UP;
    legal     = (mode_q == MODE_IDLE) || (mode_q == MODE_SHORT) ||
                (mode_q == MODE_RELEASE) || (mode_q == MODE_LONG) ||
                (mode_q == MODE_CHECK);
  end

  always_comb begin
    mode_d  = mode_q;
    press_d = press_q;
    hold_d  = hold_q;
    rel_d   = rel_q;
    valid   = 1'b0;
    code    = BTN_RELEASE;
    if (legal && !tick_i.control_permitted) begin
      mode_d = MODE_OFF;
      valid  = 1'b1;
    end else begin
      case (mode_q)
        MODE_IDLE: begin
          if (gap_bad || err_small) begin
            mode_d  = MODE_SHORT;
            press_d = '0;
            valid   = 1'b1;
            code    = gap_bad ? BTN_DISTANCE : spd_btn;
          end else if (err_big) begin
            mode_d = MODE_LONG;
            hold_d = '0;
            valid  = 1'b1;
            code   = spd_btn;
          end
        end
        MODE_SHORT: begin
          press_d = (press_q == '1) ? press_q : press_q + 1'b1;
          if (press_q > cfg_i.short_press_ticks) begin
            mode_d = MODE_RELEASE;
            rel_d  = '0;
            valid  = 1'b1;
          end
        end
        MODE_RELEASE: begin
          rel_d = (rel_q == '1) ? rel_q : rel_q + 1'b1;
          if (rel_q > cfg_i.release_ticks) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_LONG: begin
          hold_d = (hold_q == '1) ? hold_q : hold_q + 1'b1;
          if (hold_q > cfg_i.hold_check_ticks) begin
            mode_d = MODE_CHECK;
          end
        end
        MODE_CHECK: begin
          valid = 1'b1;
          if (gap_bad || !err_big) begin
            mode_d = MODE_RELEASE;
            rel_d  = '0;
          end else begin
            mode_d = MODE_LONG;
            hold_d = '0;
            code   = spd_btn;
          end
        end
        default: begin
          mode_d = tick_i.control_permitted ? MODE_IDLE : MODE_OFF;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_OFF;
      press_q <= '0;
      hold_q  <= '0;
      rel_q   <= '0;
    end else if (advance_i) begin
      mode_q  <= mode_d;
      press_q <= press_d;
      hold_q  <= hold_d;
      rel_q   <= rel_d;
    end
  end

  assign res_o = '{valid: valid, code: code, mode: mode_q};

endmodule

### hdl/setpoint_to_button_press_sequencer.sv
// top level of the set-point to cruise button press sequencer
// depends on spbs_pkg and spbs_fsm
//
// usage:
//   input channel: one control tick per transaction (target speed and gap,
//   reported set speed and gap, control permission), in_valid_i / in_stall_o
//   output channel: at most one button code per tick, out_valid_o / out_stall_i
//   config channel: cfg_valid_i / cfg_ready_o with a register index and
//   8-bit data; ready is always high, write only while the block is idle
//   path: an accepted tick waits in the input register, is evaluated against
//   the mode state, and its button code, if any, goes to the result register
//   throughput: one tick per cycle while the output is not stalled; the input
//   register and the result register each hold one tick, and the mode update
//   is a single pass of compares and counter increments
//   stall: while the result register is full and stalled, the tick in the
//   input register waits and in_stall_o rises; no tick is dropped
//   reset: mode off, counters zero, registers at their reset values,
//   both channels empty
module setpoint_to_button_press_sequencer (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [spbs_pkg::SpeedW-1:0] desired_speed_i,
  input  logic [spbs_pkg::GapW-1:0]   target_gap_i,
  input  logic [spbs_pkg::SpeedW-1:0] current_set_speed_i,
  input  logic [spbs_pkg::GapW-1:0]   current_set_gap_i,
  input  logic                       control_permitted_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [1:0]                 button_code_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [1:0]                 cfg_index_i,
  input  logic [spbs_pkg::TickW-1:0]  cfg_data_i
);
  import spbs_pkg::*;

  logic  in_valid_q;
  tick_t tick_q;
  cfg_t  cfg_q;
  logic  out_valid_q, out_valid_d;
  btn_e  btn_q;
  logic  fire;
  logic  in_take;
  res_t  res;

  assign fire       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !fire;
  assign in_take    = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (fire) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      tick_q <= '{desired_speed: desired_speed_i, target_gap: target_gap_i,
                  current_set_speed: current_set_speed_i,
                  current_set_gap: current_set_gap_i,
                  control_permitted: control_permitted_i};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{short_press_ticks: ShortPressRst, hold_check_ticks: HoldCheckRst,
                 release_ticks: ReleaseRst, long_press_threshold: LongThreshRst};
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_SHORT_PRESS: cfg_q.short_press_ticks    <= cfg_data_i;
        CFG_HOLD_CHECK:  cfg_q.hold_check_ticks     <= cfg_data_i;
        CFG_RELEASE:     cfg_q.release_ticks        <= cfg_data_i;
        CFG_LONG_THRESH: cfg_q.long_press_threshold <= cfg_data_i;
        default: ;
      endcase
    end
  end

  spbs_fsm u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .advance_i (fire),
    .tick_i    (tick_q),
    .cfg_i     (cfg_q),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = res.valid;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire && res.valid) begin
      btn_q <= res.code;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign button_code_o = btn_q;

  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q)
    else $error("input stalled with empty input register");

  a_permit_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && !tick_q.control_permitted && res.mode != MODE_OFF
      && res.mode <= MODE_CHECK
    |=> out_valid_o && button_code_o == BTN_RELEASE)
    else $error("permission loss did not send release");

  a_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !fire |=> !out_valid_o)
    else $error("result repeated after it was taken");

  a_off_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire && res.mode == MODE_OFF |-> !res.valid)
    else $error("button sent from off mode");

endmodule
